>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the indexed insert/remove array.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define IIAR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define IIAR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define IIAR_ASSERT(name, clk, rst_n, prop)
`define IIAR_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

>>> rtl/iiar_pkg.sv
// Shared opcodes, status codes and cell commands of the indexed insert/remove array.
`default_nettype none
package iiar_pkg;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_POP    = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_GET    = 3'd4;
  localparam logic [2:0] OP_SET    = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADIDX = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned POSITION_W = 5;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 5;

  // What every cell of the row does at the next clock edge.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_INSERT,
    CMD_REMOVE
  } cmd_e;

endpackage
`default_nettype wire

>>> rtl/iiar_cell.sv
// One storage cell of the array row: holds an element and shifts with its neighbors.
`default_nettype none
module iiar_cell #(
  parameter int unsigned ELEM_WIDTH = 8,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire iiar_pkg::cmd_e        cmd_i,
  input  wire logic [IDX_W-1:0]      idx_i,
  input  wire logic [IDX_W-1:0]      rd_idx_i,
  input  wire logic [ELEM_WIDTH-1:0] val_i,
  input  wire logic [ELEM_WIDTH-1:0] left_i,
  input  wire logic [ELEM_WIDTH-1:0] right_i,
  output logic      [ELEM_WIDTH-1:0] data_o,
  output logic      [ELEM_WIDTH-1:0] rd_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [ELEM_WIDTH-1:0] data_q, data_d;
  logic                  at_idx, above_idx;

  assign at_idx    = (idx_i == MyIdx);
  assign above_idx = (MyIdx > idx_i);

  always_comb begin
    data_d = data_q;
    case (cmd_i)
      iiar_pkg::CMD_WRITE: begin
        if (at_idx) data_d = val_i;
      end
      iiar_pkg::CMD_INSERT: begin
        // Cells above the insertion point take the element from below.
        if (at_idx) data_d = val_i;
        else if (above_idx) data_d = left_i;
      end
      iiar_pkg::CMD_REMOVE: begin
        if (at_idx || above_idx) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (rd_idx_i == MyIdx) ? data_q : '0;

endmodule
`default_nettype wire

>>> rtl/indexed_insert_remove_array.sv
// Top level of the indexed insert/remove array: decode, row of cells and result register.
`default_nettype none
`include "assert_macros.svh"
// The block keeps an ordered list of up to DEPTH elements in a row of cells. Every
// input transfer carries one operation (push, insert at, pop, remove at, get, set)
// and yields exactly one result transfer with the value read, a status code, the
// element count after the operation and an empty flag. All cells compare their own
// position with the index and shift in parallel, so a new input transfer is taken
// every cycle while the result register is free or being drained. A failed operation
// reports its status and leaves the list unchanged.
module indexed_insert_remove_array_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ELEM_WIDTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] opcode, [7:3] position, [15:8] value_in
  input  wire logic [15:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] value_out, [9:8] status, [14:10] count, [15] is_empty
  output logic      [15:0] m_axis_tdata
);

  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W  = (FILL_W > iiar_pkg::POSITION_W) ?
                                   FILL_W : iiar_pkg::POSITION_W;
  localparam logic [FILL_W-1:0] FillMax = FILL_W'(DEPTH);

  logic [iiar_pkg::OPCODE_W-1:0]   opcode;
  logic [iiar_pkg::POSITION_W-1:0] position;
  logic [iiar_pkg::VALUE_W-1:0]    value_in;
  logic                            accept;

  assign opcode   = s_axis_tdata[2:0];
  assign position = s_axis_tdata[7:3];
  assign value_in = s_axis_tdata[15:8];
  assign accept   = s_axis_tvalid && s_axis_tready;

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [CMP_W-1:0]  pos_ext, fill_ext;
  logic              full, empty;

  assign pos_ext  = CMP_W'(position);
  assign fill_ext = CMP_W'(fill_q);
  assign full     = (fill_q == FillMax);
  assign empty    = (fill_q == '0);

  iiar_pkg::cmd_e        cmd;
  logic [IDX_W-1:0]      idx, rd_idx;
  logic                  rd_en;
  logic [1:0]            status;
  logic [ELEM_WIDTH-1:0] val_elem;

  assign val_elem = ELEM_WIDTH'(value_in);

  always_comb begin
    cmd    = iiar_pkg::CMD_NONE;
    idx    = IDX_W'(pos_ext);
    rd_idx = IDX_W'(pos_ext);
    rd_en  = 1'b0;
    status = iiar_pkg::ST_OK;
    fill_d = fill_q;
    case (opcode)
      iiar_pkg::OP_PUSH: begin
        if (full) begin
          status = iiar_pkg::ST_FULL;
        end else begin
          cmd    = iiar_pkg::CMD_WRITE;
          idx    = IDX_W'(fill_q);
          fill_d = fill_q + FILL_W'(1);
        end
      end
      iiar_pkg::OP_INSERT: begin
        if (pos_ext > fill_ext) begin
          status = iiar_pkg::ST_BADIDX;
        end else if (full) begin
          status = iiar_pkg::ST_FULL;
        end else begin
          cmd    = iiar_pkg::CMD_INSERT;
          fill_d = fill_q + FILL_W'(1);
        end
      end
      iiar_pkg::OP_POP: begin
        if (empty) begin
          status = iiar_pkg::ST_EMPTY;
        end else begin
          rd_idx = IDX_W'(fill_q - FILL_W'(1));
          rd_en  = 1'b1;
          fill_d = fill_q - FILL_W'(1);
        end
      end
      iiar_pkg::OP_REMOVE: begin
        if (pos_ext >= fill_ext) begin
          status = iiar_pkg::ST_BADIDX;
        end else begin
          cmd    = iiar_pkg::CMD_REMOVE;
          fill_d = fill_q - FILL_W'(1);
        end
      end
      iiar_pkg::OP_GET: begin
        if (pos_ext >= fill_ext) status = iiar_pkg::ST_BADIDX;
        else rd_en = 1'b1;
      end
      iiar_pkg::OP_SET: begin
        if (pos_ext >= fill_ext) status = iiar_pkg::ST_BADIDX;
        else cmd = iiar_pkg::CMD_WRITE;
      end
      default: status = iiar_pkg::ST_OK;
    endcase
  end

  iiar_pkg::cmd_e        cell_cmd;
  logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
  logic [ELEM_WIDTH-1:0] cell_rd   [DEPTH];

  assign cell_cmd = accept ? cmd : iiar_pkg::CMD_NONE;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    // The top cell never receives from above; it keeps its own element.
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_right
      assign right = cell_data[i+1];
    end
    iiar_cell #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .IDX_W     (IDX_W),
      .INDEX     (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .idx_i   (idx),
      .rd_idx_i(rd_idx),
      .val_i   (val_elem),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  logic [ELEM_WIDTH-1:0] rd_any;

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  logic                              out_valid_q;
  logic [iiar_pkg::VALUE_W-1:0]      out_value_q;
  logic [iiar_pkg::STATUS_W-1:0]     out_status_q;
  logic [iiar_pkg::COUNT_W-1:0]      out_count_q;
  logic                              out_empty_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q  <= rd_en ? iiar_pkg::VALUE_W'(rd_any) : '0;
      out_status_q <= status;
      out_count_q  <= iiar_pkg::COUNT_W'(fill_d);
      out_empty_q  <= (fill_d == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_empty_q, out_count_q, out_status_q, out_value_q};

  `IIAR_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FillMax)
  `IIAR_ASSERT(a_fill_moves_on_transfer, clk_i, rst_ni, (fill_q != $past(fill_q)) |-> $past(accept))
  `IIAR_ASSERT(a_result_follows, clk_i, rst_ni, accept |=> m_axis_tvalid)
  `IIAR_ASSERT(a_full_means_depth, clk_i, rst_ni, (accept && status == iiar_pkg::ST_FULL) |-> full)
  `IIAR_ASSERT(a_empty_pop_flag, clk_i, rst_ni, (m_axis_tvalid && out_status_q == iiar_pkg::ST_EMPTY) |-> out_empty_q)

endmodule
`default_nettype wire
